// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

   localparam int UNIT_SHIFT = 2;  // 4-byte units

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FAIL    = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_IDX1,
      RD_SH
   } rd_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      rd_sel_type rd_sel;
      logic       chk;
      logic       advance;
      logic       a_setup;
      logic       a_keep;
      logic       a_wr1;
      logic       a_wr2;
      logic       append;
      logic       nxt_cap;
      logic       fr_dec;
      logic       sh_up;
      logic       sh_down;
      logic       respond;
      logic [1:0] rsp_status;
      logic       rsp_from_brk;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic is_free_cmd;
      logic need_zero;
      logic addr_null;
      logic cnt_zero;
      logic hit;
      logic last;
      logic split_ok;
      logic append_ok;
      logic fr_shift;
      logic sh_done;
   } stat_type;

endpackage

`default_nettype wire

// ----- sv/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- sv/ffha_dp.sv -----
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: block table RAM, count and break, scan and merge arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_dp import ffha_pkg::*; #(
   parameter int HEAP_UNITS   = 4096,
   parameter int HEADER_UNITS = 8,
   parameter int MAX_BLOCKS   = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_type     ctl,
   output stat_type         stat,
   input  wire logic        req_cmd,
   input  wire logic [14:0] req_size_bytes,
   input  wire logic [13:0] req_payload_addr,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [13:0]      rsp_result_addr
);

   localparam int UW = $clog2(HEAP_UNITS + 1);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int XW = ((UW > 14) ? UW : 14) + 3;
   localparam int EW = 2 * UW + 1;
   localparam logic [XW-1:0] H_X    = XW'(HEADER_UNITS);
   localparam logic [XW-1:0] HEAP_X = XW'(HEAP_UNITS);
   localparam logic [CW-1:0] MAX_C  = CW'(MAX_BLOCKS);

   logic          cmd_ff;
   logic [13:0]   need_ff;
   logic [13:0]   addr_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [UW-1:0] brk_ff, brk_in;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] sh_ff, sh_last_ff;
   logic [1:0]    dist_ff;
   logic [UW-1:0] cur_s_ff, cur_u_ff, prv_s_ff, prv_u_ff, nxt_u_ff;
   logic          prv_f_ff, nxt_f_ff;
   logic          rsp_strobe_ff;
   logic [1:0]    rsp_status_ff;
   logic [13:0]   rsp_addr_ff;

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [UW-1:0] rd_s, rd_u;
   logic          rd_f;

   ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_s = rd_data[EW-1 -: UW];
   assign rd_u = rd_data[UW:1];
   assign rd_f = rd_data[0];

   function automatic logic [XW-1:0] pay_x(input logic [UW-1:0] s);
      logic [XW-1:0] t;
      t = (XW'(s) + H_X) << UNIT_SHIFT;
      return t;
   endfunction

   // merge terms for a free
   logic          nf, pf, last;
   logic [XW-1:0] units_k, munits;
   logic [UW-1:0] mstart;
   logic [IW-1:0] j_idx, src0;
   logic [1:0]    r_cnt;
   logic [CW-1:0] c_new;
   logic          tail;
   logic [XW-1:0] pay_sel;

   always_comb begin
      last    = (CW'(idx_ff) + CW'(1)) == count_ff;
      nf      = !last && nxt_f_ff;
      pf      = (idx_ff != '0) && prv_f_ff;
      units_k = nf ? (XW'(cur_u_ff) + H_X + XW'(nxt_u_ff)) : XW'(cur_u_ff);
      munits  = pf ? (XW'(prv_u_ff) + H_X + units_k) : units_k;
      mstart  = pf ? prv_s_ff : cur_s_ff;
      j_idx   = idx_ff - IW'(pf);
      r_cnt   = 2'(nf) + 2'(pf);
      c_new   = count_ff - CW'(r_cnt);
      tail    = (CW'(j_idx) + CW'(1)) == c_new;
      src0    = IW'(CW'(idx_ff) + CW'(nf) + CW'(1));
      pay_sel = pay_x(ctl.rsp_from_brk ? brk_ff : cur_s_ff);
   end

   always_comb begin
      stat.is_free_cmd = (cmd_ff == CMD_FREE);
      stat.need_zero   = (need_ff == '0);
      stat.addr_null   = (addr_ff == '0);
      stat.cnt_zero    = (count_ff == '0);
      stat.last        = last;
      stat.hit         = (cmd_ff == CMD_FREE) ? (pay_x(rd_s) == XW'(addr_ff))
                                              : (rd_f && (XW'(rd_u) >= XW'(need_ff)));
      stat.split_ok    = (XW'(cur_u_ff) >= XW'(need_ff) + H_X + XW'(1))
                         && (count_ff < MAX_C);
      stat.append_ok   = (count_ff < MAX_C)
                         && (XW'(brk_ff) + H_X + XW'(need_ff) <= HEAP_X);
      stat.fr_shift    = !tail && (r_cnt != 2'd0);
      stat.sh_done     = (sh_ff == sh_last_ff);
   end

   // table read address
   always_comb begin
      case (ctl.rd_sel)
         RD_IDX1: rd_addr = idx_ff + IW'(1);
         RD_SH:   rd_addr = sh_ff;
         default: rd_addr = idx_ff;
      endcase
   end

   // table write port, one writer per cycle
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = '0;
      if (ctl.a_keep) begin
         wr_en   = 1'b1;
         wr_data = {cur_s_ff, cur_u_ff, 1'b0};
      end else if (ctl.a_wr1) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff + IW'(1);
         wr_data = {UW'(XW'(cur_s_ff) + H_X + XW'(need_ff)),
                    UW'(XW'(cur_u_ff) - XW'(need_ff) - H_X), 1'b1};
      end else if (ctl.a_wr2) begin
         wr_en   = 1'b1;
         wr_data = {cur_s_ff, UW'(need_ff), 1'b0};
      end else if (ctl.append) begin
         wr_en   = 1'b1;
         wr_addr = IW'(count_ff);
         wr_data = {brk_ff, UW'(need_ff), 1'b0};
      end else if (ctl.fr_dec && !tail) begin
         wr_en   = 1'b1;
         wr_addr = j_idx;
         wr_data = {mstart, UW'(munits), 1'b1};
      end else if (ctl.sh_up) begin
         wr_en   = 1'b1;
         wr_addr = sh_ff + IW'(1);
         wr_data = rd_data;
      end else if (ctl.sh_down) begin
         wr_en   = 1'b1;
         wr_addr = sh_ff - IW'(dist_ff);
         wr_data = rd_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      brk_in   = brk_ff;
      if (ctl.a_wr2) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.append) begin
         count_in = count_ff + CW'(1);
         brk_in   = UW'(XW'(brk_ff) + H_X + XW'(need_ff));
      end else if (ctl.fr_dec) begin
         if (tail) begin
            count_in = c_new - CW'(1);
            brk_in   = mstart;
         end else begin
            count_in = c_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         brk_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         brk_ff        <= brk_in;
         rsp_strobe_ff <= ctl.respond;
      end
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         need_ff <= 14'((16'(req_size_bytes) + 16'd3) >> UNIT_SHIFT);
         addr_ff <= req_payload_addr;
         idx_ff  <= '0;
      end
      if (ctl.chk) begin
         cur_s_ff <= rd_s;
         cur_u_ff <= rd_u;
      end
      if (ctl.advance) begin
         prv_s_ff <= rd_s;
         prv_u_ff <= rd_u;
         prv_f_ff <= rd_f;
         idx_ff   <= idx_ff + IW'(1);
      end
      if (ctl.nxt_cap) begin
         nxt_u_ff <= rd_u;
         nxt_f_ff <= rd_f;
      end
      if (ctl.a_setup) begin
         sh_ff      <= IW'(count_ff - CW'(1));
         sh_last_ff <= idx_ff + IW'(1);
      end else if (ctl.fr_dec) begin
         sh_ff      <= src0;
         sh_last_ff <= IW'(count_ff - CW'(1));
         dist_ff    <= r_cnt;
      end else if (ctl.sh_up) begin
         sh_ff <= sh_ff - IW'(1);
      end else if (ctl.sh_down) begin
         sh_ff <= sh_ff + IW'(1);
      end
      if (ctl.respond) begin
         rsp_status_ff <= ctl.rsp_status;
         rsp_addr_ff   <= (ctl.rsp_status == ST_OK && cmd_ff == CMD_ALLOC)
                          ? pay_sel[13:0] : 14'd0;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;

endmodule

`default_nettype wire

// ----- sv/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences scan, split, append, merge and table shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl import ffha_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire stat_type stat,
   output ctl_type       ctl
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SC_RD,
      S_SC_CHK,
      S_A_HIT,
      S_SHU_RD,
      S_SHU_WR,
      S_A_WR1,
      S_A_WR2,
      S_APPEND,
      S_FR_NRD,
      S_FR_NCAP,
      S_FR_DEC,
      S_SHD_RD,
      S_SHD_WR
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.is_free_cmd) begin
               if (stat.need_zero) begin
                  ctl.respond    = 1'b1;
                  ctl.rsp_status = ST_FAIL;
                  state_in       = S_IDLE;
               end else if (stat.cnt_zero) begin
                  state_in = S_APPEND;
               end else begin
                  state_in = S_SC_RD;
               end
            end else if (stat.addr_null) begin
               ctl.respond = 1'b1;
               state_in    = S_IDLE;
            end else if (stat.cnt_zero) begin
               ctl.respond    = 1'b1;
               ctl.rsp_status = ST_NOMATCH;
               state_in       = S_IDLE;
            end else begin
               state_in = S_SC_RD;
            end
         end
         S_SC_RD: begin
            ctl.rd_sel = RD_IDX;
            state_in   = S_SC_CHK;
         end
         S_SC_CHK: begin
            ctl.chk = 1'b1;
            if (stat.hit) begin
               if (!stat.is_free_cmd) begin
                  state_in = S_A_HIT;
               end else if (stat.last) begin
                  state_in = S_FR_DEC;
               end else begin
                  state_in = S_FR_NRD;
               end
            end else if (stat.last) begin
               if (!stat.is_free_cmd) begin
                  state_in = S_APPEND;
               end else begin
                  ctl.respond    = 1'b1;
                  ctl.rsp_status = ST_NOMATCH;
                  state_in       = S_IDLE;
               end
            end else begin
               ctl.advance = 1'b1;
               state_in    = S_SC_RD;
            end
         end
         S_A_HIT: begin
            ctl.a_setup = 1'b1;
            if (stat.split_ok) begin
               state_in = stat.last ? S_A_WR1 : S_SHU_RD;
            end else begin
               ctl.a_keep  = 1'b1;
               ctl.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SHU_RD: begin
            ctl.rd_sel = RD_SH;
            state_in   = S_SHU_WR;
         end
         S_SHU_WR: begin
            ctl.sh_up = 1'b1;
            state_in  = stat.sh_done ? S_A_WR1 : S_SHU_RD;
         end
         S_A_WR1: begin
            ctl.a_wr1 = 1'b1;
            state_in  = S_A_WR2;
         end
         S_A_WR2: begin
            ctl.a_wr2   = 1'b1;
            ctl.respond = 1'b1;
            state_in    = S_IDLE;
         end
         S_APPEND: begin
            ctl.respond = 1'b1;
            if (stat.append_ok) begin
               ctl.append       = 1'b1;
               ctl.rsp_from_brk = 1'b1;
            end else begin
               ctl.rsp_status = ST_FAIL;
            end
            state_in = S_IDLE;
         end
         S_FR_NRD: begin
            ctl.rd_sel = RD_IDX1;
            state_in   = S_FR_NCAP;
         end
         S_FR_NCAP: begin
            ctl.nxt_cap = 1'b1;
            state_in    = S_FR_DEC;
         end
         S_FR_DEC: begin
            ctl.fr_dec = 1'b1;
            if (stat.fr_shift) begin
               state_in = S_SHD_RD;
            end else begin
               ctl.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SHD_RD: begin
            ctl.rd_sel = RD_SH;
            state_in   = S_SHD_WR;
         end
         S_SHD_WR: begin
            ctl.sh_down = 1'b1;
            if (stat.sh_done) begin
               ctl.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_SHD_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ----- sv/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block split, neighbor merge and break
// handling over an address-ordered block table.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_cmd / req_size_bytes / req_payload_addr; the
//   transaction is taken on the edge where start is high and busy is low.
//   busy drops on the edge that raises rsp_strobe. The answer appears on
//   rsp_status / rsp_result_addr for exactly one cycle, flagged by
//   rsp_strobe; the receiver cannot hold it off. The next transaction may be
//   presented in the same cycle that rsp_strobe is high.
// Sequence from accept to rsp_strobe high:
//   decode, then per entry scanned a registered table read and a compare,
//   per entry moved when a split opens a slot or a merge closes one a read
//   and a write, then the update. Scan and move cover opposite ends of the
//   table, so the slowest case is a free merging into its left neighbor. A
//   zero-size alloc, a null free or a free on an empty heap answers from
//   decode, an alloc on an empty heap from the append step after it. A new
//   transaction is taken only once the last has answered and busy is low.
// Reset:
//   Clears the block count and the break (empty heap); table contents are
//   not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int HEAP_UNITS   = 4096,
   parameter int HEADER_UNITS = 8,
   parameter int MAX_BLOCKS   = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_cmd,
   input  wire logic [14:0] req_size_bytes,
   input  wire logic [13:0] req_payload_addr,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [13:0]      rsp_result_addr
);

   ctl_type  ctl;   // controller commands
   stat_type stat;  // datapath conditions

   ffha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   ffha_dp #(
      .HEAP_UNITS   (HEAP_UNITS),
      .HEADER_UNITS (HEADER_UNITS),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_size_bytes   (req_size_bytes),
      .req_payload_addr (req_payload_addr),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_result_addr  (rsp_result_addr)
   );

   // an accepted transaction always raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // an answer only follows work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction in progress");

   // one answer per transaction, never on back-to-back cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // failures and mismatches carry a null address
   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_result_addr == 14'd0)
      else $error("non-ok response with nonzero address");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit heap allocator: a directed table of
// edge cases, then ~700 random alloc/free transactions scored against an
// in-bench model of the block table, split, merge and break logic.
// ----------------------------------------------------------------------------

module tb_top import ffha_pkg::*; ();

   localparam int HEAP_UNITS   = 4096;
   localparam int HEADER_UNITS = 8;
   localparam int MAX_BLOCKS   = 64;
   localparam int N_RANDOM     = 700;
   localparam int DRAIN_CYCLES = 4 * MAX_BLOCKS + 40;  // worst-case latency plus margin

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [14:0] req_size_bytes;
   logic [13:0] req_payload_addr;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [13:0] rsp_result_addr;

   first_fit_heap_allocator u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_size_bytes  (req_size_bytes),
      .req_payload_addr(req_payload_addr),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_result_addr (rsp_result_addr)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Heap model: address-ordered block table, same widths as the block.
   // ------------------------------------------------------------------
   bit [12:0] heap_start [MAX_BLOCKS];
   bit [12:0] heap_units [MAX_BLOCKS];
   bit        heap_free  [MAX_BLOCKS];
   int        heap_count;
   int        heap_brk;

   // expected answers, oldest first
   bit [1:0]  want_status [$];
   bit [13:0] want_addr   [$];

   int errors;
   int n_alloc_ok, n_alloc_fail, n_free_ok, n_nomatch, n_table_full, n_splits;
   int burst_left;
   bit calm;  // no gaps in the current stretch

   function automatic int payload_at(int k);
      return (heap_start[k] + HEADER_UNITS) * 4;
   endfunction

   // remove entry k, close the hole
   function automatic void table_remove(int k);
      for (int i = k; i + 1 < heap_count; i++) begin
         heap_start[i] = heap_start[i+1];
         heap_units[i] = heap_units[i+1];
         heap_free[i]  = heap_free[i+1];
      end
      heap_count--;
   endfunction

   // Computes status and payload address for one transaction and updates the table.
   task automatic heap_predict(input bit c, input bit [14:0] bytes, input bit [13:0] addr,
                               output bit [1:0] st, output bit [13:0] ra);
      int need;
      int k;
      bit found;
      st = ST_OK;
      ra = '0;
      found = 1'b0;
      if (c == CMD_ALLOC) begin
         if (bytes == 0) begin
            st = ST_FAIL;
         end else begin
            need = (int'(bytes) + 3) >> UNIT_SHIFT;
            for (int i = 0; i < heap_count && !found; i++) begin
               if (heap_free[i] && heap_units[i] >= need) begin
                  found = 1'b1;
                  if (heap_units[i] >= need + HEADER_UNITS + 1) begin
                     if (heap_count < MAX_BLOCKS) begin
                        // split: the remainder becomes a new free block after i
                        for (int j = heap_count; j > i + 1; j--) begin
                           heap_start[j] = heap_start[j-1];
                           heap_units[j] = heap_units[j-1];
                           heap_free[j]  = heap_free[j-1];
                        end
                        heap_count++;
                        heap_start[i+1] = 13'(heap_start[i] + HEADER_UNITS + need);
                        heap_units[i+1] = 13'(heap_units[i] - need - HEADER_UNITS);
                        heap_free[i+1]  = 1'b1;
                        heap_units[i]   = 13'(need);
                        n_splits++;
                     end else begin
                        n_table_full++;  // table full: whole block goes out unsplit
                     end
                  end
                  heap_free[i] = 1'b0;
                  ra = 14'(payload_at(i));
               end
            end
            if (!found) begin
               if (heap_count >= MAX_BLOCKS) begin
                  st = ST_FAIL;
                  n_table_full++;
               end else if (heap_brk + HEADER_UNITS + need > HEAP_UNITS) begin
                  st = ST_FAIL;
               end else begin
                  heap_start[heap_count] = 13'(heap_brk);
                  heap_units[heap_count] = 13'(need);
                  heap_free[heap_count]  = 1'b0;
                  ra = 14'(payload_at(heap_count));
                  heap_count++;
                  heap_brk += HEADER_UNITS + need;
               end
            end
         end
      end else if (addr != 0) begin
         k = heap_count;
         for (int i = 0; i < heap_count; i++)
            if (k == heap_count && payload_at(i) == addr)
               k = i;
         if (k >= heap_count) begin
            st = ST_NOMATCH;
         end else begin
            heap_free[k] = 1'b1;
            if (k + 1 < heap_count && heap_free[k+1]) begin
               heap_units[k] = 13'(heap_units[k] + HEADER_UNITS + heap_units[k+1]);
               table_remove(k + 1);
            end
            if (k > 0 && heap_free[k-1]) begin
               heap_units[k-1] = 13'(heap_units[k-1] + HEADER_UNITS + heap_units[k]);
               table_remove(k);
               k--;
            end
            // last block gives its space back to the break
            if (k + 1 == heap_count) begin
               heap_brk = heap_start[k];
               table_remove(k);
            end
         end
      end
      case (st)
         ST_FAIL:    n_alloc_fail++;
         ST_NOMATCH: n_nomatch++;
         default:    if (c == CMD_ALLOC) n_alloc_ok++; else n_free_ok++;
      endcase
   endtask

   // Drive one transaction from a falling edge; returns at the falling edge after accept.
   task automatic send_txn(input bit c, input bit [14:0] bytes, input bit [13:0] addr,
                           input bit typed, input bit [1:0] t_st, input bit [13:0] t_ra);
      bit [1:0]  p_st;
      bit [13:0] p_ra;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 5) == 0)
            calm = ~calm;
         gap = calm ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      start            = 1'b1;
      req_cmd          = c;
      req_size_bytes   = bytes;
      req_payload_addr = addr;
      do @(posedge clock); while (busy);
      heap_predict(c, bytes, addr, p_st, p_ra);
      if (typed) begin
         want_status.push_back(t_st);
         want_addr.push_back(t_ra);
      end else begin
         want_status.push_back(p_st);
         want_addr.push_back(p_ra);
      end
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response checker: every strobe pops the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (want_status.size() == 0) begin
            $error("unexpected response: status=%0d addr=%0d", rsp_status, rsp_result_addr);
            errors++;
         end else begin
            if (rsp_status !== want_status[0]) begin
               $error("rsp_status: expected %0d, got %0d", want_status[0], rsp_status);
               errors++;
            end
            if (rsp_result_addr !== want_addr[0]) begin
               $error("rsp_result_addr: expected %0d, got %0d", want_addr[0],
                      rsp_result_addr);
               errors++;
            end
            void'(want_status.pop_front());
            void'(want_addr.pop_front());
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   typedef struct {
      bit        cmd;
      bit [14:0] bytes;
      bit [13:0] addr;
      bit        typed;   // expected value given in the row
      bit [1:0]  st;
      bit [13:0] ra;
   } stim_row_type;

   stim_row_type dir_rows [$];

   function automatic void row(bit c, bit [14:0] b, bit [13:0] a, bit typed = 0,
                               bit [1:0] st = ST_OK, bit [13:0] ra = 0);
      stim_row_type r;
      r = '{c, b, a, typed, st, ra};
      dir_rows.push_back(r);
   endfunction

   initial begin
      int sel;
      int pick;
      bit [14:0] bytes;
      bit [13:0] addr;

      errors = 0;
      burst_left = 0;
      calm = 1'b0;
      heap_count = 0;
      heap_brk = 0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_ALLOC;
      req_size_bytes = '0;
      req_payload_addr = '0;

      // empty-heap corners, full-heap single block, then split/merge walk
      row(CMD_FREE,  0,     0,     1, ST_OK,      0);   // null free
      row(CMD_FREE,  0,     4,     1, ST_NOMATCH, 0);   // unknown address
      row(CMD_ALLOC, 0,     0,     1, ST_FAIL,    0);   // zero size
      row(CMD_ALLOC, 32767, 0,     1, ST_FAIL,    0);   // max field
      row(CMD_ALLOC, 16384, 0,     1, ST_FAIL,    0);   // just past heap end
      row(CMD_ALLOC, 16352, 0,     1, ST_OK,      32);  // fills heap exactly
      row(CMD_ALLOC, 1,     0,     1, ST_FAIL,    0);   // heap full
      row(CMD_FREE,  0,     32,    1, ST_OK,      0);   // last block, break back to 0
      row(CMD_ALLOC, 1,     16383, 1, ST_OK,      32);
      row(CMD_ALLOC, 40,    0);
      row(CMD_ALLOC, 4,     0);
      row(CMD_ALLOC, 400,   0);
      row(CMD_FREE,  0,     32);                        // first block, no merge
      row(CMD_ALLOC, 3,     0);                         // reuse, no split
      row(CMD_FREE,  0,     68);                        // middle block
      row(CMD_FREE,  0,     32);                        // merge with right
      row(CMD_FREE,  0,     32);                        // free of a free block
      row(CMD_ALLOC, 8,     0);                         // split the merged block
      row(CMD_FREE,  0,     16380, 1, ST_NOMATCH, 0);
      row(CMD_FREE,  0,     10922);                     // alternating bits
      row(CMD_ALLOC, 21845, 0,     1, ST_FAIL,    0);
      row(CMD_ALLOC, 10922, 5461);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_txn(dir_rows[i].cmd, dir_rows[i].bytes, dir_rows[i].addr,
                  dir_rows[i].typed, dir_rows[i].st, dir_rows[i].ra);

      // Random part. Every 150 transactions a fill stretch of small allocs drives
      // the table to full; otherwise a mix of allocs, frees of live blocks and noise.
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) begin
            // hold off until everything outstanding has answered
            start = 1'b0;
            while (want_status.size() != 0) @(negedge clock);
         end
         sel = $urandom_range(0, 99);
         if ((n % 150) < 70 && sel < 90) begin
            send_txn(CMD_ALLOC, 15'($urandom_range(1, 24)), 14'($urandom), 0, ST_OK, 0);
         end else if (sel < 45) begin
            case ($urandom_range(0, 9))
               0:       bytes = 15'($urandom_range(4000, 16384));
               1:       bytes = 15'($urandom);
               2, 3:    bytes = 15'($urandom_range(1, 1024));
               default: bytes = 15'($urandom_range(1, 96));
            endcase
            send_txn(CMD_ALLOC, bytes, 14'($urandom), 0, ST_OK, 0);
         end else if (sel < 88 && heap_count > 0) begin
            pick = int'($urandom_range(0, heap_count - 1));
            addr = 14'(payload_at(pick));
            send_txn(CMD_FREE, 15'($urandom), addr, 0, ST_OK, 0);
         end else if (sel < 92) begin
            send_txn(CMD_FREE, 15'($urandom), 0, 0, ST_OK, 0);
         end else if (sel < 95) begin
            send_txn(CMD_ALLOC, 0, 14'($urandom), 0, ST_OK, 0);
         end else begin
            send_txn(CMD_FREE, 15'($urandom), 14'($urandom), 0, ST_OK, 0);
         end
      end
      start = 1'b0;

      while (want_status.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered: %0d allocs ok, %0d alloc failures, %0d frees ok, %0d bad frees",
               n_alloc_ok, n_alloc_fail, n_free_ok, n_nomatch);
      $display("         %0d splits, %0d table-full cases", n_splits, n_table_full);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
